// File: rtl/plic_pkg.sv
// Package: shared types and codes for the positional insert/delete list.
`timescale 1ns / 1ps

package plic_pkg;

  localparam int POS_W  = 8;   // position and length field width
  localparam int WORD_W = 32;  // list word width
  localparam int GRP    = 16;  // cells per first-level read OR group

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // Command broadcast to every cell for one cycle
  typedef struct packed {
    logic              ins;  // insert at idx, shift higher cells up
    logic              del;  // delete at idx, shift higher cells down
    logic              rd;   // drive the word at idx on the read bus
    logic [POS_W-1:0]  idx;  // 0-based target index
  } cmd_t;

endpackage

// File: rtl/plic_cell.sv
// One list cell: holds a word and trades it with its neighbors on insert/delete.
`timescale 1ns / 1ps

module plic_cell #(
  parameter int INDEX = 0
) (
  input  logic                                clk,
  input  plic_pkg::cmd_t                      cmd,
  input  logic signed [plic_pkg::WORD_W-1:0]  value_in,
  input  logic signed [plic_pkg::WORD_W-1:0]  prev_in,
  input  logic signed [plic_pkg::WORD_W-1:0]  next_in,
  output logic signed [plic_pkg::WORD_W-1:0]  data_out,
  output logic signed [plic_pkg::WORD_W-1:0]  rd_out
);

  logic signed [plic_pkg::WORD_W-1:0] data;
  logic signed [plic_pkg::WORD_W-1:0] data_next;
  logic                               hit;
  logic                               above;

  assign hit   = (int'(cmd.idx) == INDEX);
  assign above = (int'(cmd.idx) < INDEX);

  // Next word: new value at the target, shift up or down past it
  always_comb begin
    data_next = data;
    if (cmd.ins) begin
      if (hit) begin
        data_next = value_in;
      end else if (above) begin
        data_next = prev_in;
      end
    end else if (cmd.del && (hit || above)) begin
      data_next = next_in;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Gated read bus contribution, zero unless this cell is the target of a read or delete
  assign rd_out   = ((cmd.del || cmd.rd) && hit) ? data : '0;
  assign data_out = data;

endmodule

// File: rtl/positional_insert_delete_list.sv
// Top level: ordered list of signed words held in a chain of shifting cells.
// An accepted request moves through s1 (cells updated, group ORs registered) and then s2
// (outputs, done registered). busy is high over s1 and s2 and blocks new requests, set by
//   the cell update cycle and the registered two-level OR tree on the read path.
// The receiver cannot stall; done is high for one cycle and the result registers then hold.
// Reset (rst, synchronous) empties the list and idles the pipeline; cell words are not cleared.
`timescale 1ns / 1ps

module positional_insert_delete_list #(
  parameter int CAPACITY = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          op,
  input  logic [plic_pkg::POS_W-1:0]          position,
  input  logic signed [plic_pkg::WORD_W-1:0]  value,
  output logic                                done,
  output logic [1:0]                          status,
  output logic signed [plic_pkg::WORD_W-1:0]  out_value,
  output logic [plic_pkg::POS_W-1:0]          list_length
);

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int CMPW   = ((CW > plic_pkg::POS_W) ? CW : plic_pkg::POS_W) + 1;
  localparam int GROUPS = (CAPACITY + plic_pkg::GRP - 1) / plic_pkg::GRP;

  // Request register and pipeline control
  logic                               s1;
  logic                               s2;
  logic [1:0]                         req_op;
  logic [plic_pkg::POS_W-1:0]         req_pos;
  logic signed [plic_pkg::WORD_W-1:0] req_value;
  logic [CW-1:0]                      count;
  logic [CW-1:0]                      count_next;
  plic_pkg::status_t                  st_a;
  plic_pkg::status_t                  st_b;
  logic [plic_pkg::POS_W-1:0]         len_b;
  plic_pkg::cmd_t                     cmd;
  logic                               accept;

  logic signed [plic_pkg::WORD_W-1:0] cell_data [CAPACITY];
  logic signed [plic_pkg::WORD_W-1:0] cell_rd   [CAPACITY];
  logic signed [plic_pkg::WORD_W-1:0] grp_or    [GROUPS];
  logic signed [plic_pkg::WORD_W-1:0] grp_q     [GROUPS];
  logic signed [plic_pkg::WORD_W-1:0] tree_or;

  assign accept = start && !busy;
  assign busy   = s1 || s2;

  // Decode: range/full checks against the current count, cell command and next count
  always_comb begin
    logic [CMPW-1:0] pos_x;
    logic [CMPW-1:0] cnt_x;
    pos_x      = CMPW'(req_pos);
    cnt_x      = CMPW'(count);
    st_a       = plic_pkg::ST_OK;
    count_next = count;
    cmd.ins    = 1'b0;
    cmd.del    = 1'b0;
    cmd.rd     = 1'b0;
    cmd.idx    = req_pos - plic_pkg::POS_W'(1);
    case (req_op)
      plic_pkg::OP_INSERT: begin
        if (pos_x == '0 || pos_x > cnt_x + CMPW'(1)) begin
          st_a = plic_pkg::ST_BADPOS;
        end else if (int'(count) >= CAPACITY) begin
          st_a = plic_pkg::ST_FULL;
        end else begin
          cmd.ins    = s1;
          count_next = count + CW'(1);
        end
      end
      plic_pkg::OP_DELETE: begin
        if (pos_x == '0 || pos_x > cnt_x) begin
          st_a = plic_pkg::ST_BADPOS;
        end else begin
          cmd.del    = s1;
          count_next = count - CW'(1);
        end
      end
      plic_pkg::OP_READ: begin
        if (pos_x == '0 || pos_x > cnt_x) begin
          st_a = plic_pkg::ST_BADPOS;
        end else begin
          cmd.rd = s1;
        end
      end
      default: begin
        st_a = plic_pkg::ST_BADPOS;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1    <= 1'b0;
      s2    <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      s1   <= accept;
      s2   <= s1;
      done <= s2;
      if (s1) begin
        count <= count_next;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op    <= op;
      req_pos   <= position;
      req_value <= value;
    end
    if (s1) begin
      st_b  <= st_a;
      len_b <= plic_pkg::POS_W'(count_next);
    end
    if (s2) begin
      status      <= st_b;
      list_length <= len_b;
      out_value   <= tree_or;
    end
  end

  // Chain of cells
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [plic_pkg::WORD_W-1:0] prev_w;
    logic signed [plic_pkg::WORD_W-1:0] next_w;
    if (k == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid_p
      assign prev_w = cell_data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_mid_n
      assign next_w = cell_data[k+1];
    end
    plic_cell #(.INDEX(k)) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .value_in (req_value),
      .prev_in  (prev_w),
      .next_in  (next_w),
      .data_out (cell_data[k]),
      .rd_out   (cell_rd[k])
    );
  end

  // First level of the read OR tree, registered per group
  for (genvar g = 0; g < GROUPS; g++) begin : g_grp
    always_comb begin
      grp_or[g] = '0;
      for (int j = 0; j < plic_pkg::GRP; j++) begin
        if (g * plic_pkg::GRP + j < CAPACITY) begin
          grp_or[g] = grp_or[g] | cell_rd[g * plic_pkg::GRP + j];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (s1) begin
        grp_q[g] <= grp_or[g];
      end
    end
  end

  // Second level across groups
  always_comb begin
    tree_or = '0;
    for (int g = 0; g < GROUPS; g++) begin
      tree_or = tree_or | grp_q[g];
    end
  end

endmodule

// File: rtl/plic_checker.sv
// Checker: port-level timing and result properties of the list block, with its bind.
`timescale 1ns / 1ps

module plic_checker #(
  parameter int CAPACITY = 128
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic                                done,
  input logic [1:0]                          status,
  input logic signed [plic_pkg::WORD_W-1:0]  out_value,
  input logic [plic_pkg::POS_W-1:0]          list_length
);

  // Every accepted request gets its result strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("result strobe missing after accepted request");

  // An accepted request occupies the block on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // Errors carry a zero word
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != plic_pkg::ST_OK) |-> (out_value == '0))
    else $error("nonzero word on error result");

  // Full status only when the list is at capacity
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    (done && status == plic_pkg::ST_FULL) |->
      (list_length == plic_pkg::POS_W'(CAPACITY)))
    else $error("full status with list below capacity");

endmodule

bind positional_insert_delete_list plic_checker #(.CAPACITY(CAPACITY)) u_plic_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .out_value   (out_value),
  .list_length (list_length)
);
